FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the SNI extractor modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_pkg
// Types and constants of the TLS client hello SNI extractor.
// ----------------------------------------------------------------------------
package tse_pkg;

	typedef enum logic [22:0] {
		PH_HDR0  = 23'h000001,
		PH_HDR1  = 23'h000002,
		PH_HDR2  = 23'h000004,
		PH_HDR3  = 23'h000008,
		PH_HDR4  = 23'h000010,
		PH_HSTYP = 23'h000020,
		PH_SID   = 23'h000040,
		PH_CS0   = 23'h000080,
		PH_CS1   = 23'h000100,
		PH_CM    = 23'h000200,
		PH_EX0   = 23'h000400,
		PH_EX1   = 23'h000800,
		PH_ET0   = 23'h001000,
		PH_ET1   = 23'h002000,
		PH_EL0   = 23'h004000,
		PH_EL1S  = 23'h008000,
		PH_EL1O  = 23'h010000,
		PH_NT    = 23'h020000,
		PH_NL0   = 23'h040000,
		PH_NL1H  = 23'h080000,
		PH_NL1O  = 23'h100000,
		PH_NAME  = 23'h200000,
		PH_DONE  = 23'h400000
	} phase_t;

	typedef enum logic [2:0] {
		ST_FOUND      = 3'd0,
		ST_INCOMPLETE = 3'd1,
		ST_NOSNI      = 3'd2,
		ST_NOTHS      = 3'd3,
		ST_BADPKT     = 3'd4,
		ST_BADEXT     = 3'd5,
		ST_NONE       = 3'd7
	} status_t;

	typedef struct packed {
		logic [7:0]  name_byte;
		logic        name_byte_valid;
		logic        status_valid;
		logic [2:0]  status;
		logic [15:0] name_length;
	} result_t;

	localparam logic [7:0]  CONTENT_HANDSHAKE = 8'h16;
	localparam logic [7:0]  HELLO_CLIENT      = 8'h01;
	localparam logic [7:0]  VERSION_MAJOR_TLS = 8'h03;
	localparam logic [7:0]  SSL2_MINOR        = 8'h01;
	localparam logic [16:0] REC_HDR_LEN       = 17'd5;
	localparam logic [17:0] HS_TYPE_POS       = 18'd5;
	// session id length byte sits after type, length, version and random
	localparam logic [17:0] SID_LEN_POS       = 18'd43;
	localparam logic [16:0] MIN_SID_END       = 17'd44;
	localparam logic [16:0] MIN_HS_END        = 17'd6;
	localparam logic [17:0] POS_TOP           = 18'h3FFFF;

endpackage

FILE: hdl/tse_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_if
// Valid/ready channels of the SNI extractor: record bytes in, results out.
// ----------------------------------------------------------------------------
interface tse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tse_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  name_byte;
	logic        name_byte_valid;
	logic        status_valid;
	logic [2:0]  status;
	logic [15:0] name_length;

	modport source (output valid, output name_byte, output name_byte_valid,
		output status_valid, output status, output name_length, input ready);
	modport sink (input valid, input name_byte, input name_byte_valid,
		input status_valid, input status, input name_length, output ready);
endinterface

FILE: hdl/tse_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_parser
// Length-counter walk over the record; one byte per accepted word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tse_parser #(
	parameter int unsigned NAME_MAX = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              res_valid,
	output tse_pkg::result_t  res
);

	localparam logic [15:0] NameMaxW = 16'(NAME_MAX);

	tse_pkg::phase_t  phase_q, phase_d;
	tse_pkg::status_t verdict_q, verdict_d, st;
	logic [17:0] pos_q;
	logic [16:0] rec_end_q, rec_end_d;
	logic [17:0] fe_q, fe_d;
	logic [17:0] ext_end_q, ext_end_d;
	logic [17:0] sl_end_q, sl_end_d;
	logic [15:0] acc_q, acc_d;
	logic [7:0]  hdr0_q, hdr0_d, vmaj_q, vmaj_d, vmin_q, vmin_d;
	logic [15:0] sent_q, sent_d;
	logic        zero_q, zero_d;
	logic [15:0] flen_q, flen_d;
	logic        emit;
	logic [18:0] fe1, fe3, sum8, sum16, captured;
	logic [15:0] len16;
	logic        hdr_bad;

	assign fe1      = {1'b0, fe_q} + 19'd1;
	assign fe3      = {1'b0, fe_q} + 19'd3;
	assign len16    = {acc_q[15:8], data_byte};
	assign sum8     = fe1 + {11'd0, data_byte};
	assign sum16    = fe1 + {3'd0, len16};
	assign captured = {1'b0, pos_q} + 19'd1;
	assign hdr_bad  = (hdr0_q[7] && vmin_q == tse_pkg::SSL2_MINOR)
		|| hdr0_q != tse_pkg::CONTENT_HANDSHAKE || vmaj_q < tse_pkg::VERSION_MAJOR_TLS;

	always_comb begin
		phase_d   = phase_q;
		verdict_d = verdict_q;
		rec_end_d = rec_end_q;
		fe_d      = fe_q;
		ext_end_d = ext_end_q;
		sl_end_d  = sl_end_q;
		acc_d     = acc_q;
		hdr0_d    = hdr0_q;
		vmaj_d    = vmaj_q;
		vmin_d    = vmin_q;
		sent_d    = sent_q;
		zero_d    = zero_q;
		flen_d    = flen_q;
		emit      = 1'b0;
		if (take && phase_q != tse_pkg::PH_DONE && pos_q == fe_q) begin
			unique case (phase_q)
				tse_pkg::PH_HDR0: begin
					hdr0_d = data_byte; phase_d = tse_pkg::PH_HDR1; fe_d = fe1[17:0];
				end
				tse_pkg::PH_HDR1: begin
					vmaj_d = data_byte; phase_d = tse_pkg::PH_HDR2; fe_d = fe1[17:0];
				end
				tse_pkg::PH_HDR2: begin
					vmin_d = data_byte; phase_d = tse_pkg::PH_HDR3; fe_d = fe1[17:0];
				end
				tse_pkg::PH_HDR3: begin
					acc_d = {data_byte, 8'h00}; phase_d = tse_pkg::PH_HDR4; fe_d = fe1[17:0];
				end
				tse_pkg::PH_HDR4: begin
					rec_end_d = tse_pkg::REC_HDR_LEN + {1'b0, len16};
					if (hdr_bad) begin
						phase_d = tse_pkg::PH_DONE;
					end else if (rec_end_d < tse_pkg::MIN_HS_END) begin
						verdict_d = tse_pkg::ST_BADPKT; phase_d = tse_pkg::PH_DONE;
					end else begin
						phase_d = tse_pkg::PH_HSTYP; fe_d = tse_pkg::HS_TYPE_POS;
					end
				end
				tse_pkg::PH_HSTYP: begin
					if (data_byte != tse_pkg::HELLO_CLIENT || rec_end_q < tse_pkg::MIN_SID_END) begin
						verdict_d = tse_pkg::ST_BADPKT; phase_d = tse_pkg::PH_DONE;
					end else begin
						phase_d = tse_pkg::PH_SID; fe_d = tse_pkg::SID_LEN_POS;
					end
				end
				tse_pkg::PH_SID: begin
					if (sum8 + 19'd2 > {2'b0, rec_end_q}) begin
						verdict_d = tse_pkg::ST_BADPKT; phase_d = tse_pkg::PH_DONE;
					end else begin
						phase_d = tse_pkg::PH_CS0; fe_d = sum8[17:0];
					end
				end
				tse_pkg::PH_CS0: begin
					acc_d = {data_byte, 8'h00}; phase_d = tse_pkg::PH_CS1; fe_d = fe1[17:0];
				end
				tse_pkg::PH_CS1: begin
					if (sum16 + 19'd1 > {2'b0, rec_end_q}) begin
						verdict_d = tse_pkg::ST_BADPKT; phase_d = tse_pkg::PH_DONE;
					end else begin
						phase_d = tse_pkg::PH_CM; fe_d = sum16[17:0];
					end
				end
				tse_pkg::PH_CM: begin
					// SSL 3.0 hello may end right after compression methods
					if (sum8 == {2'b0, rec_end_q} && vmaj_q == tse_pkg::VERSION_MAJOR_TLS
						&& vmin_q == 8'h00) begin
						verdict_d = tse_pkg::ST_NOSNI; phase_d = tse_pkg::PH_DONE;
					end else if (sum8 + 19'd2 > {2'b0, rec_end_q}) begin
						verdict_d = tse_pkg::ST_BADPKT; phase_d = tse_pkg::PH_DONE;
					end else begin
						phase_d = tse_pkg::PH_EX0; fe_d = sum8[17:0];
					end
				end
				tse_pkg::PH_EX0: begin
					acc_d = {data_byte, 8'h00}; phase_d = tse_pkg::PH_EX1; fe_d = fe1[17:0];
				end
				tse_pkg::PH_EX1: begin
					if (sum16 > {2'b0, rec_end_q}) begin
						verdict_d = tse_pkg::ST_BADPKT; phase_d = tse_pkg::PH_DONE;
					end else begin
						ext_end_d = sum16[17:0];
						if (fe1 + 19'd4 <= sum16) begin
							phase_d = tse_pkg::PH_ET0; fe_d = fe1[17:0];
						end else begin
							verdict_d = (fe1 == sum16) ? tse_pkg::ST_NOSNI : tse_pkg::ST_BADEXT;
							phase_d = tse_pkg::PH_DONE;
						end
					end
				end
				tse_pkg::PH_ET0: begin
					acc_d = {8'h00, data_byte}; phase_d = tse_pkg::PH_ET1; fe_d = fe1[17:0];
				end
				tse_pkg::PH_ET1: begin
					acc_d = {acc_q[7:0], data_byte}; phase_d = tse_pkg::PH_EL0; fe_d = fe1[17:0];
				end
				tse_pkg::PH_EL0: begin
					// extension type zero carries the host names
					phase_d = (acc_q == 16'd0) ? tse_pkg::PH_EL1S : tse_pkg::PH_EL1O;
					fe_d = fe1[17:0];
					acc_d = {data_byte, 8'h00};
				end
				tse_pkg::PH_EL1O: begin
					if (sum16 + 19'd4 <= {1'b0, ext_end_q}) begin
						phase_d = tse_pkg::PH_ET0; fe_d = sum16[17:0];
					end else begin
						verdict_d = (sum16 == {1'b0, ext_end_q}) ?
							tse_pkg::ST_NOSNI : tse_pkg::ST_BADEXT;
						phase_d = tse_pkg::PH_DONE;
					end
				end
				tse_pkg::PH_EL1S: begin
					if (sum16 > {1'b0, ext_end_q}) begin
						verdict_d = tse_pkg::ST_BADEXT; phase_d = tse_pkg::PH_DONE;
					end else begin
						// skip the 2-byte list length
						sl_end_d = sum16[17:0];
						if (fe3 + 19'd3 < sum16) begin
							phase_d = tse_pkg::PH_NT; fe_d = fe3[17:0];
						end else begin
							verdict_d = (fe3 == sum16) ? tse_pkg::ST_NOSNI : tse_pkg::ST_BADPKT;
							phase_d = tse_pkg::PH_DONE;
						end
					end
				end
				tse_pkg::PH_NT: begin
					acc_d = {8'h00, data_byte}; phase_d = tse_pkg::PH_NL0; fe_d = fe1[17:0];
				end
				tse_pkg::PH_NL0: begin
					phase_d = (acc_q == 16'd0) ? tse_pkg::PH_NL1H : tse_pkg::PH_NL1O;
					fe_d = fe1[17:0];
					acc_d = {data_byte, 8'h00};
				end
				tse_pkg::PH_NL1O: begin
					if (sum16 > {1'b0, sl_end_q}) begin
						verdict_d = tse_pkg::ST_BADPKT; phase_d = tse_pkg::PH_DONE;
					end else if (sum16 + 19'd3 < {1'b0, sl_end_q}) begin
						phase_d = tse_pkg::PH_NT; fe_d = sum16[17:0];
					end else begin
						verdict_d = (sum16 == {1'b0, sl_end_q}) ?
							tse_pkg::ST_NOSNI : tse_pkg::ST_BADPKT;
						phase_d = tse_pkg::PH_DONE;
					end
				end
				tse_pkg::PH_NL1H: begin
					if (sum16 > {1'b0, sl_end_q}) begin
						verdict_d = tse_pkg::ST_BADPKT; phase_d = tse_pkg::PH_DONE;
					end else begin
						flen_d = len16;
						verdict_d = tse_pkg::ST_FOUND;
						sl_end_d = sum16[17:0];
						if (len16 == 16'd0) begin
							phase_d = tse_pkg::PH_DONE;
						end else begin
							phase_d = tse_pkg::PH_NAME; fe_d = fe1[17:0];
						end
					end
				end
				tse_pkg::PH_NAME: begin
					if (!zero_q && sent_q < NameMaxW) begin
						if (data_byte == 8'h00) begin
							zero_d = 1'b1;
						end else begin
							emit = 1'b1;
							sent_d = sent_q + 16'd1;
						end
					end
					if (fe1 >= {1'b0, sl_end_q}) begin
						phase_d = tse_pkg::PH_DONE;
					end else begin
						fe_d = fe1[17:0];
					end
				end
				default: begin
					phase_d = tse_pkg::PH_DONE;
				end
			endcase
		end
	end

	// final status, first match wins
	always_comb begin
		priority if (captured < 19'd5) begin
			st = tse_pkg::ST_INCOMPLETE;
		end else if (hdr0_d[7] && vmin_d == tse_pkg::SSL2_MINOR) begin
			st = tse_pkg::ST_NOSNI;
		end else if (hdr0_d != tse_pkg::CONTENT_HANDSHAKE) begin
			st = tse_pkg::ST_NOTHS;
		end else if (vmaj_d < tse_pkg::VERSION_MAJOR_TLS) begin
			st = tse_pkg::ST_NOSNI;
		end else if (captured < {2'b0, rec_end_d}) begin
			st = tse_pkg::ST_INCOMPLETE;
		end else if (verdict_d == tse_pkg::ST_NONE) begin
			st = tse_pkg::ST_BADPKT;
		end else begin
			st = verdict_d;
		end
	end

	assign res_valid           = take && (emit || last_byte);
	assign res.name_byte       = emit ? data_byte : 8'h00;
	assign res.name_byte_valid = emit;
	assign res.status_valid    = last_byte;
	assign res.status          = last_byte ? st : 3'd0;
	assign res.name_length     = (last_byte && st == tse_pkg::ST_FOUND) ? flen_d : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tse_pkg::PH_HDR0;
			verdict_q <= tse_pkg::ST_NONE;
			pos_q     <= '0;
			rec_end_q <= '0;
			fe_q      <= '0;
			ext_end_q <= '0;
			sl_end_q  <= '0;
			acc_q     <= '0;
			hdr0_q    <= '0;
			vmaj_q    <= '0;
			vmin_q    <= '0;
			sent_q    <= '0;
			zero_q    <= 1'b0;
			flen_q    <= '0;
		end else if (take) begin
			if (last_byte) begin
				// packet over: back to reset for the next one
				phase_q   <= tse_pkg::PH_HDR0;
				verdict_q <= tse_pkg::ST_NONE;
				pos_q     <= '0;
				rec_end_q <= '0;
				fe_q      <= '0;
				ext_end_q <= '0;
				sl_end_q  <= '0;
				acc_q     <= '0;
				hdr0_q    <= '0;
				vmaj_q    <= '0;
				vmin_q    <= '0;
				sent_q    <= '0;
				zero_q    <= 1'b0;
				flen_q    <= '0;
			end else begin
				phase_q   <= phase_d;
				verdict_q <= verdict_d;
				if (pos_q != tse_pkg::POS_TOP) begin
					pos_q <= pos_q + 18'd1;
				end
				rec_end_q <= rec_end_d;
				fe_q      <= fe_d;
				ext_end_q <= ext_end_d;
				sl_end_q  <= sl_end_d;
				acc_q     <= acc_d;
				hdr0_q    <= hdr0_d;
				vmaj_q    <= vmaj_d;
				vmin_q    <= vmin_d;
				sent_q    <= sent_d;
				zero_q    <= zero_d;
				flen_q    <= flen_d;
			end
		end
	end

	`ASSERT_NEXT(a_rearm_after_last, clk, arst_n, take && last_byte, phase_q == tse_pkg::PH_HDR0 && pos_q == 18'd0, "parser not rearmed after last byte")
	`ASSERT_IMPLY(a_name_only_in_name, clk, arst_n, res_valid && res.name_byte_valid, phase_q == tse_pkg::PH_NAME && sent_q < NameMaxW, "name byte outside host name field")
	`ASSERT_IMPLY(a_name_cap, clk, arst_n, 1'b1, sent_q <= NameMaxW, "name byte count over limit")

endmodule

FILE: hdl/tse_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_out_buf
// Output register with a skid entry; decouples ready from the consumer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tse_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tse_pkg::result_t push_word,
	output logic             can_take,
	tse_out_if.source        result
);

	tse_pkg::result_t main_q, skid_q;
	logic             main_v_q, skid_v_q;
	logic             pop;

	assign pop      = main_v_q && result.ready;
	assign can_take = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= push_word;
			end else begin
				main_q <= push_word;
			end
		end
	end

	assign result.valid           = main_v_q;
	assign result.name_byte       = main_q.name_byte;
	assign result.name_byte_valid = main_q.name_byte_valid;
	assign result.status_valid    = main_q.status_valid;
	assign result.status          = main_q.status;
	assign result.name_length     = main_q.name_length;

	`ASSERT_IMPLY(a_skid_behind_main, clk, arst_n, skid_v_q, main_v_q, "skid entry held with output register empty")
	`ASSERT_IMPLY(a_no_overrun, clk, arst_n, skid_v_q, !push, "word pushed while both entries full")
	`ASSERT_NEXT(a_hold_stalled, clk, arst_n, main_v_q && !result.ready, main_v_q, "result word dropped while stalled")

endmodule

FILE: hdl/tls_sni_extractor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_sni_extractor_top
// TLS client hello server-name extractor, one record byte per word.
// ----------------------------------------------------------------------------
// Usage: feed the captured TLS record one byte per word on rec, with
// last_byte set on the final captured byte. A byte is taken each cycle
// as long as the output register and its skid entry are not both full,
// so rec.ready only drops when result is stalled. A result word is
// registered in the output buffer when the byte that causes it is taken:
// host name characters as they pass (up to the first zero byte or
// NAME_MAX bytes), and on the last byte one word with status_valid set
// that carries the final status and, when found, the host name length.
// Drop the streamed name unless the status is found. The parser rearms
// itself after the last byte; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module tls_sni_extractor_top #(
	parameter int unsigned NAME_MAX = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	tse_in_if.sink     rec,
	tse_out_if.source  result
);

	logic             take;
	logic             can_take;
	logic             res_valid;
	tse_pkg::result_t res;

	assign rec.ready = can_take;
	assign take      = rec.valid && can_take;

	tse_parser #(
		.NAME_MAX(NAME_MAX)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (rec.data_byte),
		.last_byte (rec.last_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	tse_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_word (res),
		.can_take  (can_take),
		.result    (result)
	);

endmodule
